### rtl/srts_pkg.sv
// Shared constants, widths and fixed-point helpers for the timestamp line-fit block.
`default_nettype none

package srts_pkg;

    localparam int SRTS_WINDOW = 100;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int SIDX_W   = 32;
    localparam int SSQ_W    = 48;
    localparam int SVAL_W   = 48;
    localparam int SXY_W    = 64;
    localparam int Q_W      = 48;
    localparam int OP_W     = 64;
    localparam int WIDE_W   = 128;
    localparam int SH_W     = 7;

    // Binary point of the slope and intercept.
    localparam logic [SH_W-1:0] FRAC_SH = 7'd24;
    // Slope scaling used by the evaluate request.
    localparam logic [SH_W-1:0] EVAL_SH = 7'd47;

    localparam logic [SAMPLE_W-1:0] LOW_QUARTER  = 16'h4000;
    localparam logic [SAMPLE_W-1:0] HIGH_QUARTER = 16'hC000;
    localparam logic [SAMPLE_W-1:0] HALF_RANGE   = 16'h8000;
    localparam logic [TIME_W-1:0]   WRAP_STEP    = 32'h0001_0000;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -128'sh8000_0000_0000;

    function automatic logic signed [WIDE_W-1:0] ext_op(input logic signed [OP_W-1:0] v);
        return {{(WIDE_W-OP_W){v[OP_W-1]}}, v};
    endfunction

    function automatic logic signed [OP_W-1:0] ext_q(input logic signed [Q_W-1:0] v);
        return {{(OP_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[Q_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[Q_W-1:0];
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    // Arithmetic right shift that rounds toward zero.
    function automatic logic signed [WIDE_W-1:0] shr_trunc(input logic signed [WIDE_W-1:0] v,
                                                          input logic [SH_W-1:0] sh);
        logic signed [WIDE_W-1:0] bias;
        bias = (128'sd1 <<< sh) - 128'sd1;
        return v[WIDE_W-1] ? ((v + bias) >>> sh) : (v >>> sh);
    endfunction

endpackage

`default_nettype wire

### rtl/srts_if.sv
// Request and result channel interfaces with valid/ready handshake.
`default_nettype none

interface srts_in_if;
    import srts_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [SAMPLE_W-1:0]        sample;
    logic signed [TIME_W-1:0]   query_time;

    modport source (output valid, output command, output sample, output query_time,
                    input ready);
    modport sink (input valid, input command, input sample, input query_time,
                  output ready);
endinterface

interface srts_out_if;
    import srts_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [SAMPLE_W-1:0]        fitted_value;
    logic signed [TIME_W-1:0]   corrected_time;

    modport source (output valid, output fitted_value, output corrected_time,
                    input ready);
    modport sink (input valid, input fitted_value, input corrected_time,
                  output ready);
endinterface

`default_nettype wire

### rtl/srts_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module srts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/srts_mul.sv
// Shift-and-add signed multiplier, one multiplier bit per cycle, stops early.
`default_nettype none

module srts_mul
    import srts_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [OP_W-1:0]   a,
    input  wire logic signed [OP_W-1:0]   b,
    output logic                          done,
    output logic signed [WIDE_W-1:0]      product
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [WIDE_W-1:0]   acc_reg, acc_next;
    logic [WIDE_W-1:0]   mcand_reg, mcand_next;
    logic [OP_W-1:0]     mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            neg_next    = a[OP_W-1] ^ b[OP_W-1];
            acc_next    = '0;
            mcand_next  = {{(WIDE_W-OP_W){1'b0}}, (a[OP_W-1] ? OP_W'(-a) : OP_W'(a))};
            mplier_next = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = neg_reg ? $signed(-acc_reg) : $signed(acc_reg);

endmodule

`default_nettype wire

### rtl/srts_div.sv
// Restoring divider: signed wide numerator over positive divisor, truncating toward zero.
`default_nettype none

module srts_div
    import srts_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [WIDE_W-1:0] num,
    input  wire logic [OP_W-1:0]          den,
    output logic                          done,
    output logic signed [WIDE_W-1:0]      quotient
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        neg_reg, neg_next;
    logic [$clog2(WIDE_W)-1:0]   cnt_reg, cnt_next;
    logic [WIDE_W-1:0]           m_reg, m_next;
    logic [WIDE_W-1:0]           q_reg, q_next;
    logic [OP_W-1:0]             rem_reg, rem_next;
    logic [OP_W-1:0]             den_reg, den_next;
    logic [OP_W:0]               trial;

    assign trial = {rem_reg, m_reg[WIDE_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = num[WIDE_W-1];
            m_next    = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            m_next = m_reg << 1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = OP_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[OP_W-1:0];
                q_next   = {q_reg[WIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        m_reg   <= m_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-q_reg) : $signed(q_reg);

endmodule

`default_nettype wire

### rtl/sliding_regression_timestamp_sync.sv
// Evaluate request: one serial multiply of the slope by the 32-bit query.
// Feed request: mostly two 128-step divisions and six serial multiplies; the first sample
// has a single point, so it skips the slope and takes one division and two multiplies.
// A feed that finds 3*WINDOW+1 samples counted first regenerates WINDOW points on the
// current line; after a re-seed this recurs every 2*WINDOW+1 feeds.
// One request is in work at a time; a finished result waits in the output register.
// Reset clears the sums, fit and counters at once; the ring RAM is not cleared.
`default_nettype none

module sliding_regression_timestamp_sync
    import srts_pkg::*;
#(
    parameter int WINDOW = SRTS_WINDOW
) (
    input  wire logic clk,
    input  wire logic rst_n,
    srts_in_if.sink   item,
    srts_out_if.source result
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int JW = $clog2(WINDOW + 1);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_EVAL    = 5'd1;
    localparam logic [4:0] ST_RS_BASE = 5'd2;
    localparam logic [4:0] ST_RS_GEN  = 5'd3;
    localparam logic [4:0] ST_UNWRAP  = 5'd4;
    localparam logic [4:0] ST_REMOVE  = 5'd5;
    localparam logic [4:0] ST_ADD     = 5'd6;
    localparam logic [4:0] ST_FIT     = 5'd7;
    localparam logic [4:0] ST_M1      = 5'd8;
    localparam logic [4:0] ST_M2      = 5'd9;
    localparam logic [4:0] ST_M3      = 5'd10;
    localparam logic [4:0] ST_M4      = 5'd11;
    localparam logic [4:0] ST_D1      = 5'd12;
    localparam logic [4:0] ST_ICPT    = 5'd13;
    localparam logic [4:0] ST_M5      = 5'd14;
    localparam logic [4:0] ST_D2      = 5'd15;
    localparam logic [4:0] ST_M6      = 5'd16;
    localparam logic [4:0] ST_OUT     = 5'd17;

    logic [4:0]                 state_reg, state_next;
    logic                       reseed_reg, reseed_next;
    logic [AW-1:0]              k_reg, k_next;
    logic [AW-1:0]              slot_reg, slot_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [TIME_W-1:0]          wrap_reg, wrap_next;
    logic                       flag_reg, flag_next;
    logic [SIDX_W-1:0]          sum_index_reg, sum_index_next;
    logic [SSQ_W-1:0]           sum_sq_reg, sum_sq_next;
    logic [SVAL_W-1:0]          sum_value_reg, sum_value_next;
    logic [SXY_W-1:0]           sum_cross_reg, sum_cross_next;
    logic signed [Q_W-1:0]      slope_reg, slope_next;
    logic signed [Q_W-1:0]      icpt_reg, icpt_next;
    logic [SAMPLE_W-1:0]        lsv_reg, lsv_next;
    logic                       out_valid_reg, out_valid_next;

    logic [SAMPLE_W-1:0]        sample_reg, sample_next;
    logic [SAMPLE_W-1:0]        y_reg, y_next;
    logic [COUNT_W-1:0]         x_reg, x_next;
    logic [TIME_W-1:0]          v_reg, v_next;
    logic signed [TIME_W-1:0]   query_reg, query_next;
    logic signed [TIME_W-1:0]   corr_reg, corr_next;
    logic signed [WIDE_W-1:0]   a0_reg, a0_next;
    logic signed [Q_W-1:0]      b0_reg, b0_next;
    logic signed [WIDE_W-1:0]   acc_reg, acc_next;
    logic signed [WIDE_W-1:0]   num_reg, num_next;
    logic [SAMPLE_W-1:0]        out_fit_reg, out_fit_next;
    logic signed [TIME_W-1:0]   out_corr_reg, out_corr_next;

    logic                       mul_start_reg, mul_start_next;
    logic signed [OP_W-1:0]     mul_a_reg, mul_a_next;
    logic signed [OP_W-1:0]     mul_b_reg, mul_b_next;
    logic                       mul_done;
    logic signed [WIDE_W-1:0]   mul_prod;

    logic                       div_start_reg, div_start_next;
    logic signed [WIDE_W-1:0]   div_num_reg, div_num_next;
    logic [OP_W-1:0]            div_den_reg, div_den_next;
    logic                       div_done;
    logic signed [WIDE_W-1:0]   div_quot;

    logic                       ram_we;
    logic                       ram_re;
    logic [TIME_W-1:0]          ram_rdata;

    logic                       accept;
    logic [JW-1:0]              j_w;
    logic signed [OP_W-1:0]     j64, sx64, sy64, sxx64, x64;
    logic signed [OP_W-1:0]     t64, base64;
    logic [SAMPLE_W-1:0]        ox;
    logic signed [TIME_W-1:0]   oy;
    logic signed [TIME_W-1:0]   vy;
    logic signed [SAMPLE_W+TIME_W:0] rm_cross, add_cross;
    logic [2*SAMPLE_W-1:0]      rm_sq, add_sq;
    logic [TIME_W-1:0]          wrap_upd;
    logic signed [WIDE_W-1:0]   den_w, f_w, g_w, p_w;
    logic signed [WIDE_W-1:0]   corr_sh, gen_sh, fit_sh;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);

    assign j_w   = (count_reg > COUNT_W'(WINDOW)) ? JW'(WINDOW) : JW'(count_reg);
    assign j64   = $signed(OP_W'(j_w));
    assign sx64  = $signed({{(OP_W-SIDX_W){1'b0}}, sum_index_reg});
    assign sy64  = $signed({{(OP_W-SVAL_W){sum_value_reg[SVAL_W-1]}}, sum_value_reg});
    assign sxx64 = $signed({{(OP_W-SSQ_W){1'b0}}, sum_sq_reg});
    assign x64   = $signed({{(OP_W-COUNT_W){1'b0}}, x_reg});

    assign t64    = {{(OP_W-TIME_W){query_reg[TIME_W-1]}}, query_reg};
    assign base64 = t64 - $signed({{(OP_W-SAMPLE_W){1'b0}}, lsv_reg});

    // The entry leaving the window was written exactly WINDOW samples ago.
    assign ox        = x_reg - SAMPLE_W'(WINDOW);
    assign oy        = ram_rdata;
    assign vy        = v_reg;
    assign rm_cross  = $signed({1'b0, ox}) * oy;
    assign add_cross = $signed({1'b0, x_reg}) * vy;
    assign rm_sq     = ox * ox;
    assign add_sq    = x_reg * x_reg;

    always_comb
    begin
        wrap_upd = wrap_reg;
        if (count_reg != '0)
        begin
            if (flag_reg && (y_reg < LOW_QUARTER))
                wrap_upd = wrap_reg + WRAP_STEP;
            else if (!flag_reg && (y_reg > HIGH_QUARTER))
                wrap_upd = wrap_reg - WRAP_STEP;
        end
    end

    assign den_w = acc_reg - mul_prod;
    assign f_w   = ext_op(ext_q(icpt_reg)) + mul_prod;
    assign g_w   = a0_reg + mul_prod;
    assign p_w   = (ext_op(base64) <<< EVAL_SH) - mul_prod;

    assign corr_sh = shr_trunc(p_w, EVAL_SH);
    assign gen_sh  = shr_trunc(g_w, FRAC_SH);
    assign fit_sh  = shr_trunc(f_w, FRAC_SH);

    assign ram_we = (state_reg == ST_ADD);
    assign ram_re = (state_reg == ST_UNWRAP);

    always_comb
    begin
        state_next     = state_reg;
        reseed_next    = reseed_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        wrap_next      = wrap_reg;
        flag_next      = flag_reg;
        sum_index_next = sum_index_reg;
        sum_sq_next    = sum_sq_reg;
        sum_value_next = sum_value_reg;
        sum_cross_next = sum_cross_reg;
        slope_next     = slope_reg;
        icpt_next      = icpt_reg;
        lsv_next       = lsv_reg;
        sample_next    = sample_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        v_next         = v_reg;
        query_next     = query_reg;
        corr_next      = corr_reg;
        a0_next        = a0_reg;
        b0_next        = b0_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        out_fit_next   = out_fit_reg;
        out_corr_next  = out_corr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_EVAL)
                    begin
                        query_next     = item.query_time;
                        mul_a_next     = ext_q(slope_reg);
                        mul_b_next     = {{(OP_W-TIME_W){item.query_time[TIME_W-1]}},
                                          item.query_time};
                        mul_start_next = 1'b1;
                        state_next     = ST_EVAL;
                    end
                    else
                    begin
                        sample_next = item.sample;
                        if (count_reg > COUNT_W'(3 * WINDOW))
                        begin
                            mul_a_next     = ext_q(slope_reg);
                            mul_b_next     = $signed({{(OP_W-COUNT_W){1'b0}}, count_reg});
                            mul_start_next = 1'b1;
                            state_next     = ST_RS_BASE;
                        end
                        else
                        begin
                            y_next     = item.sample;
                            state_next = ST_UNWRAP;
                        end
                    end
                end
            end
            ST_EVAL:
            begin
                if (mul_done)
                begin
                    corr_next  = corr_sh[TIME_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_RS_BASE:
            begin
                if (mul_done)
                begin
                    a0_next        = ext_op(ext_q(icpt_reg)) + mul_prod;
                    b0_next        = slope_reg;
                    sum_index_next = '0;
                    sum_sq_next    = '0;
                    sum_value_next = '0;
                    sum_cross_next = '0;
                    wrap_next      = '0;
                    flag_next      = 1'b0;
                    count_next     = '0;
                    slot_next      = '0;
                    k_next         = '0;
                    reseed_next    = 1'b1;
                    mul_a_next     = ext_q(slope_reg);
                    mul_b_next     = -$signed(OP_W'(WINDOW));
                    mul_start_next = 1'b1;
                    state_next     = ST_RS_GEN;
                end
            end
            ST_RS_GEN:
            begin
                if (mul_done)
                begin
                    y_next     = gen_sh[SAMPLE_W-1:0];
                    state_next = ST_UNWRAP;
                end
            end
            ST_UNWRAP:
            begin
                wrap_next  = wrap_upd;
                flag_next  = (y_reg > HALF_RANGE);
                v_next     = {{(TIME_W-SAMPLE_W){1'b0}}, y_reg} + wrap_upd;
                x_next     = count_reg;
                count_next = count_reg + 1'b1;
                state_next = (count_reg >= COUNT_W'(WINDOW)) ? ST_REMOVE : ST_ADD;
            end
            ST_REMOVE:
            begin
                sum_index_next = sum_index_reg - {{(SIDX_W-SAMPLE_W){1'b0}}, ox};
                sum_sq_next    = sum_sq_reg - {{(SSQ_W-2*SAMPLE_W){1'b0}}, rm_sq};
                sum_value_next = sum_value_reg - {{(SVAL_W-TIME_W){oy[TIME_W-1]}}, oy};
                sum_cross_next = sum_cross_reg
                               - {{(SXY_W-SAMPLE_W-TIME_W-1){rm_cross[SAMPLE_W+TIME_W]}},
                                  rm_cross};
                state_next     = ST_ADD;
            end
            ST_ADD:
            begin
                sum_index_next = sum_index_reg + {{(SIDX_W-SAMPLE_W){1'b0}}, x_reg};
                sum_sq_next    = sum_sq_reg + {{(SSQ_W-2*SAMPLE_W){1'b0}}, add_sq};
                sum_value_next = sum_value_reg + {{(SVAL_W-TIME_W){vy[TIME_W-1]}}, vy};
                sum_cross_next = sum_cross_reg
                               + {{(SXY_W-SAMPLE_W-TIME_W-1){add_cross[SAMPLE_W+TIME_W]}},
                                  add_cross};
                slot_next      = (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next     = ST_FIT;
            end
            ST_FIT:
            begin
                if (j_w > JW'(1))
                begin
                    mul_a_next     = $signed(sum_cross_reg);
                    mul_b_next     = j64;
                    mul_start_next = 1'b1;
                    state_next     = ST_M1;
                end
                else
                begin
                    slope_next = '0;
                    state_next = ST_ICPT;
                end
            end
            ST_M1:
            begin
                if (mul_done)
                begin
                    acc_next       = mul_prod;
                    mul_a_next     = sy64;
                    mul_b_next     = sx64;
                    mul_start_next = 1'b1;
                    state_next     = ST_M2;
                end
            end
            ST_M2:
            begin
                if (mul_done)
                begin
                    num_next       = acc_reg - mul_prod;
                    mul_a_next     = sxx64;
                    mul_b_next     = j64;
                    mul_start_next = 1'b1;
                    state_next     = ST_M3;
                end
            end
            ST_M3:
            begin
                if (mul_done)
                begin
                    acc_next       = mul_prod;
                    mul_a_next     = sx64;
                    mul_b_next     = sx64;
                    mul_start_next = 1'b1;
                    state_next     = ST_M4;
                end
            end
            ST_M4:
            begin
                if (mul_done)
                begin
                    // A spread that is not positive leaves the slope flat.
                    if (!den_w[WIDE_W-1] && (den_w != '0))
                    begin
                        div_num_next   = num_reg <<< FRAC_SH;
                        div_den_next   = den_w[OP_W-1:0];
                        div_start_next = 1'b1;
                        state_next     = ST_D1;
                    end
                    else
                    begin
                        slope_next = '0;
                        state_next = ST_ICPT;
                    end
                end
            end
            ST_D1:
            begin
                if (div_done)
                begin
                    slope_next = sat_q(div_quot);
                    state_next = ST_ICPT;
                end
            end
            ST_ICPT:
            begin
                mul_a_next     = ext_q(slope_reg);
                mul_b_next     = sx64;
                mul_start_next = 1'b1;
                state_next     = ST_M5;
            end
            ST_M5:
            begin
                if (mul_done)
                begin
                    div_num_next   = (ext_op(sy64) <<< FRAC_SH) - mul_prod;
                    div_den_next   = OP_W'(j_w);
                    div_start_next = 1'b1;
                    state_next     = ST_D2;
                end
            end
            ST_D2:
            begin
                if (div_done)
                begin
                    icpt_next      = sat_q(div_quot);
                    mul_a_next     = ext_q(slope_reg);
                    mul_b_next     = x64;
                    mul_start_next = 1'b1;
                    state_next     = ST_M6;
                end
            end
            ST_M6:
            begin
                if (mul_done)
                begin
                    lsv_next = fit_sh[SAMPLE_W-1:0];
                    if (reseed_reg)
                    begin
                        if (k_reg == AW'(WINDOW - 1))
                        begin
                            // Window regenerated; now take the request's own sample.
                            reseed_next = 1'b0;
                            y_next      = sample_reg;
                            state_next  = ST_UNWRAP;
                        end
                        else
                        begin
                            k_next         = k_reg + 1'b1;
                            mul_a_next     = ext_q(b0_reg);
                            mul_b_next     = $signed(OP_W'(k_reg) + OP_W'(1) - OP_W'(WINDOW));
                            mul_start_next = 1'b1;
                            state_next     = ST_RS_GEN;
                        end
                    end
                    else
                    begin
                        corr_next  = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_fit_next   = lsv_reg;
                    out_corr_next  = corr_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            reseed_reg    <= 1'b0;
            k_reg         <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            wrap_reg      <= '0;
            flag_reg      <= 1'b0;
            sum_index_reg <= '0;
            sum_sq_reg    <= '0;
            sum_value_reg <= '0;
            sum_cross_reg <= '0;
            slope_reg     <= '0;
            icpt_reg      <= '0;
            lsv_reg       <= '0;
            out_valid_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reseed_reg    <= reseed_next;
            k_reg         <= k_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            wrap_reg      <= wrap_next;
            flag_reg      <= flag_next;
            sum_index_reg <= sum_index_next;
            sum_sq_reg    <= sum_sq_next;
            sum_value_reg <= sum_value_next;
            sum_cross_reg <= sum_cross_next;
            slope_reg     <= slope_next;
            icpt_reg      <= icpt_next;
            lsv_reg       <= lsv_next;
            out_valid_reg <= out_valid_next;
            mul_start_reg <= mul_start_next;
            div_start_reg <= div_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        y_reg        <= y_next;
        x_reg        <= x_next;
        v_reg        <= v_next;
        query_reg    <= query_next;
        corr_reg     <= corr_next;
        a0_reg       <= a0_next;
        b0_reg       <= b0_next;
        acc_reg      <= acc_next;
        num_reg      <= num_next;
        out_fit_reg  <= out_fit_next;
        out_corr_reg <= out_corr_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
    end

    srts_ram #(
        .WIDTH (TIME_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (v_reg),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    srts_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    srts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .num      (div_num_reg),
        .den      (div_den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign result.valid          = out_valid_reg;
    assign result.fitted_value   = out_fit_reg;
    assign result.corrected_time = out_corr_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= AW'(WINDOW - 1))
        else $error("ring slot beyond window");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(3 * WINDOW + 1))
        else $error("sample count passed the re-seed point");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_EVAL || state_reg == ST_RS_BASE ||
                      state_reg == ST_RS_GEN || state_reg == ST_M1 ||
                      state_reg == ST_M2 || state_reg == ST_M3 ||
                      state_reg == ST_M4 || state_reg == ST_M5 ||
                      state_reg == ST_M6))
        else $error("multiplier finished outside a waiting state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_D1 || state_reg == ST_D2))
        else $error("divider finished outside a waiting state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised without a finished request");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the sliding-window timestamp line-fit block.
`timescale 1ns / 1ps

module tb;
    import srts_pkg::*;

    localparam int W = SRTS_WINDOW;
    localparam int RANDOM_ITEMS = 700;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct {
        logic [SAMPLE_W-1:0]      fitted;
        logic signed [TIME_W-1:0] corrected;
    } fit_result_t;

    typedef struct {
        logic                     command;
        logic [SAMPLE_W-1:0]      sample;
        logic signed [TIME_W-1:0] query_time;
        bit                       typed;
        logic [SAMPLE_W-1:0]      fitted;
        logic signed [TIME_W-1:0] corrected;
    } stim_row_t;

    logic clk;
    logic rst_n;

    srts_in_if  in_ch();
    srts_out_if out_ch();

    sliding_regression_timestamp_sync dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch.sink),
        .result (out_ch.source)
    );

    // Predictor state of the line fit.
    logic [SAMPLE_W-1:0]      ring_x [W];
    logic [TIME_W-1:0]        ring_y [W];
    logic [COUNT_W-1:0]       n_points;
    logic [SIDX_W-1:0]        acc_x;
    logic [SSQ_W-1:0]         acc_xx;
    logic [SVAL_W-1:0]        acc_y;
    logic [SXY_W-1:0]         acc_xy;
    logic [TIME_W-1:0]        unwrap_ofs;
    logic                     was_upper;
    logic signed [Q_W-1:0]    fit_slope;
    logic signed [Q_W-1:0]    fit_icept;
    logic [SAMPLE_W-1:0]      sync_value;

    fit_result_t expected_fits[$];
    int  errors = 0;
    bit  calm = 0;
    bit  stim_done = 0;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic wide_t sat48(wide_t v);
        wide_t hi_lim, lo_lim;
        hi_lim = (wide_t'(1) <<< 47) - 1;
        lo_lim = -(wide_t'(1) <<< 47);
        if (v > hi_lim)
            return hi_lim;
        if (v < lo_lim)
            return lo_lim;
        return v;
    endfunction

    function automatic wide_t q_of(logic signed [Q_W-1:0] v);
        return {{(WIDE_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    // Fixed-point value to integer, rounding toward zero.
    function automatic wide_t q_to_int(wide_t v);
        return v / (wide_t'(1) <<< 24);
    endfunction

    function automatic void add_point(logic [SAMPLE_W-1:0] x, logic [TIME_W-1:0] v);
        int slot, j;
        logic [SAMPLE_W-1:0] ox;
        logic [TIME_W-1:0] oy;
        wide_t sx, sxx, sy, sxy, wj, num, den, f;
        slot = n_points % W;
        n_points = n_points + 1;
        j = (n_points > W) ? W : n_points;
        if (n_points > W)
        begin
            ox = ring_x[slot];
            oy = ring_y[slot];
            acc_x  = acc_x - ox;
            acc_xx = acc_xx - SSQ_W'(ox) * SSQ_W'(ox);
            acc_y  = acc_y - {{(SVAL_W-TIME_W){oy[TIME_W-1]}}, oy};
            acc_xy = acc_xy - SXY_W'(ox) * {{(SXY_W-TIME_W){oy[TIME_W-1]}}, oy};
        end
        ring_x[slot] = x;
        ring_y[slot] = v;
        acc_x  = acc_x + x;
        acc_xx = acc_xx + SSQ_W'(x) * SSQ_W'(x);
        acc_y  = acc_y + {{(SVAL_W-TIME_W){v[TIME_W-1]}}, v};
        acc_xy = acc_xy + SXY_W'(x) * {{(SXY_W-TIME_W){v[TIME_W-1]}}, v};

        sx  = {{(WIDE_W-SIDX_W){1'b0}}, acc_x};
        sxx = {{(WIDE_W-SSQ_W){1'b0}}, acc_xx};
        sy  = {{(WIDE_W-SVAL_W){acc_y[SVAL_W-1]}}, acc_y};
        sxy = {{(WIDE_W-SXY_W){acc_xy[SXY_W-1]}}, acc_xy};
        wj  = j;

        fit_slope = '0;
        if (j > 1)
        begin
            num = wj * sxy - sx * sy;
            den = wj * sxx - sx * sx;
            if (den > 0)
                fit_slope = sat48((num <<< 24) / den);
        end
        fit_icept = sat48((sy * (wide_t'(1) <<< 24) - q_of(fit_slope) * sx) / wj);
        f = q_of(fit_icept) + q_of(fit_slope) * wide_t'(x);
        sync_value = q_to_int(f);
    endfunction

    function automatic void take_sample(logic [SAMPLE_W-1:0] y);
        if (n_points != 0)
        begin
            if (was_upper && y < LOW_QUARTER)
                unwrap_ofs = unwrap_ofs + WRAP_STEP;
            else if (!was_upper && y > HIGH_QUARTER)
                unwrap_ofs = unwrap_ofs - WRAP_STEP;
        end
        was_upper = (y > HALF_RANGE);
        add_point(n_points, TIME_W'(y) + unwrap_ofs);
    endfunction

    // Rebuild a fresh window on the current line once the count runs past three windows.
    function automatic void reseed_line();
        wide_t a0, b0, g;
        a0 = q_of(fit_icept) + q_of(fit_slope) * wide_t'(n_points);
        b0 = q_of(fit_slope);
        acc_x = '0;
        acc_xx = '0;
        acc_y = '0;
        acc_xy = '0;
        unwrap_ofs = '0;
        was_upper = 0;
        n_points = '0;
        for (int k = 0; k < W; k++)
        begin
            g = a0 + b0 * wide_t'(k - W);
            take_sample(SAMPLE_W'(q_to_int(g)));
        end
    endfunction

    function automatic fit_result_t timestamp_sync_step(logic cmd, logic [SAMPLE_W-1:0] s,
                                                        logic signed [TIME_W-1:0] t);
        fit_result_t r;
        wide_t tw, base, p;
        if (cmd == CMD_FEED)
        begin
            if (n_points > 3 * W)
                reseed_line();
            take_sample(s);
            r.fitted = sync_value;
            r.corrected = '0;
        end
        else
        begin
            tw = t;
            base = tw - wide_t'(sync_value);
            p = base * (wide_t'(1) <<< 47) - tw * q_of(fit_slope);
            r.fitted = sync_value;
            r.corrected = TIME_W'(p / (wide_t'(1) <<< 47));
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        errors++;
        $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
    endtask

    // Drives one request and records its expectation once it is accepted.
    task automatic send_request(stim_row_t row);
        int gap;
        fit_result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1;
        in_ch.command    <= row.command;
        in_ch.sample     <= row.sample;
        in_ch.query_time <= row.query_time;
        do @(posedge clk); while (!in_ch.ready);
        r = timestamp_sync_step(row.command, row.sample, row.query_time);
        if (row.typed)
        begin
            r.fitted = row.fitted;
            r.corrected = row.corrected;
        end
        expected_fits.push_back(r);
    endtask

    // Result side: random back-pressure, none while calm.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (calm)
            out_ch.ready <= 1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 0;
        end
        else
        begin
            out_ch.ready <= 1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        fit_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_fits.size() == 0)
                report_mismatch("unexpected result", 0, out_ch.fitted_value);
            else
            begin
                e = expected_fits.pop_front();
                if (out_ch.fitted_value !== e.fitted)
                    report_mismatch("fitted_value", e.fitted, out_ch.fitted_value);
                if (out_ch.corrected_time !== e.corrected)
                    report_mismatch("corrected_time", e.corrected, out_ch.corrected_time);
            end
        end
    end

    initial
    begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        stim_row_t directed[$];
        stim_row_t row;
        logic [SAMPLE_W-1:0] stamp;
        int r;

        in_ch.valid = 0;
        in_ch.command = CMD_FEED;
        in_ch.sample = '0;
        in_ch.query_time = '0;
        out_ch.ready = 0;
        n_points = '0;
        acc_x = '0;
        acc_xx = '0;
        acc_y = '0;
        acc_xy = '0;
        unwrap_ofs = '0;
        was_upper = 0;
        fit_slope = '0;
        fit_icept = '0;
        sync_value = '0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Straight after reset the correction is the identity and the first fit is the sample.
        directed = '{
            '{CMD_EVAL, 16'h0000, 32'sh7FFF_FFFF, 1, 16'h0000, 32'sh7FFF_FFFF},
            '{CMD_EVAL, 16'h0000, 32'sh8000_0000, 1, 16'h0000, 32'sh8000_0000},
            '{CMD_FEED, 16'hFFFF, 32'sh0,         1, 16'hFFFF, 32'sh0},
            '{CMD_FEED, 16'h0000, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'h3FFF, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'h4000, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'h8000, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'h8001, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'h0001, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'hC001, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'hC000, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'hFFFF, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'hFFFF, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_EVAL, 16'h0000, 32'sh7FFF_FFFF, 0, 16'h0, 32'sh0},
            '{CMD_EVAL, 16'hFFFF, 32'sh8000_0000, 0, 16'h0, 32'sh0},
            '{CMD_EVAL, 16'h0000, 32'sh0,         0, 16'h0, 32'sh0},
            '{CMD_EVAL, 16'h0000, -32'sd1,        0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'h5555, 32'sh0, 0, 16'h0, 32'sh0},
            '{CMD_FEED, 16'hAAAA, 32'sh0, 0, 16'h0, 32'sh0}
        };
        foreach (directed[i])
            send_request(directed[i]);

        // Mostly a drifting, wrapping clock with jitter; some noise and stray queries.
        stamp = $urandom;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            row = '{CMD_FEED, 16'h0, 32'sh0, 0, 16'h0, 32'sh0};
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                row.command = CMD_EVAL;
                row.query_time = $urandom;
                row.sample = $urandom;
            end
            else if (r < 23)
                row.sample = $urandom;
            else
            begin
                stamp = stamp + 16'($urandom_range(200, 2000)) - 16'($urandom_range(0, 60));
                row.sample = stamp;
            end
            send_request(row);
        end
        in_ch.valid <= 0;
        calm = 0;

        while (expected_fits.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/srts_pkg.sv
rtl/srts_if.sv
rtl/srts_ram.sv
rtl/srts_mul.sv
rtl/srts_div.sv
rtl/sliding_regression_timestamp_sync.sv
sim/tb.sv
